// ===== hw/rtl/vrt_pkg.sv =====
// Shared types, constants and the axis selection table for the voxel ray traversal block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package vrt_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 10;
  localparam int DIST_BITS_DEF  = 32;

  // Fixed port widths
  localparam int VOX_W  = 10;
  localparam int TIN_W  = 32;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 12;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(1024);
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRID_Z = 2'd2;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // One request as held in the input register
  typedef struct packed {
    logic             op;
    logic [VOX_W-1:0] start_x;
    logic [VOX_W-1:0] start_y;
    logic [VOX_W-1:0] start_z;
    logic [2:0]       step_neg;
    logic [TIN_W-1:0] tmax_x;
    logic [TIN_W-1:0] tmax_y;
    logic [TIN_W-1:0] tmax_z;
    logic [TIN_W-1:0] tdelta_x;
    logic [TIN_W-1:0] tdelta_y;
    logic [TIN_W-1:0] tdelta_z;
  } item_t;

  // One result
  typedef struct packed {
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
    logic             voxel_valid;
    logic             done;
    logic [CNT_W-1:0] count;
  } res_t;

  // code = {tx<ty, tx<tz, ty<tz}; ties follow the table
  function automatic axis_t axis_lookup(input logic [2:0] code);
    axis_t ax;
    case (code)
      3'b000:  ax = AXIS_Z;
      3'b001:  ax = AXIS_Y;
      3'b010:  ax = AXIS_Z;
      3'b011:  ax = AXIS_Y;
      3'b100:  ax = AXIS_Z;
      3'b101:  ax = AXIS_Z;
      3'b110:  ax = AXIS_X;
      3'b111:  ax = AXIS_X;
      default: ax = AXIS_Z;
    endcase
    return ax;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vrt_bounds.sv =====
// Grid bounds check: all three coordinates below the clamped grid sizes.
// Depends on vrt_pkg.
`default_nettype none

module vrt_bounds import vrt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic [2:0][COORD_BITS:0] cur,
  input  wire logic [2:0][CFG_W-1:0]    grid_size,
  output logic                          bounds_ok
);

  localparam int CUR_W = COORD_BITS + 1;
  localparam int CMP_W = (CUR_W > CFG_W) ? CUR_W : CFG_W;
  localparam logic [CMP_W-1:0] SPAN = CMP_W'(1) << COORD_BITS;

  logic [2:0]            ok;
  logic [2:0][CMP_W-1:0] eff;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // clamp sizes beyond the coordinate range
    assign eff[a] = (CMP_W'(grid_size[a]) > SPAN) ? SPAN : CMP_W'(grid_size[a]);
    assign ok[a]  = CMP_W'(cur[a]) < eff[a];
  end

  assign bounds_ok = &ok;

endmodule

`default_nettype wire

// ===== hw/rtl/vrt_core.sv =====
// Ray state registers and the combinational load / step datapath.
// Depends on vrt_pkg and vrt_bounds.
`default_nettype none

module vrt_core import vrt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    fire,
  input  wire item_t                   item,
  input  wire logic [2:0][CFG_W-1:0]   grid_size,
  output res_t                         res
);

  localparam int CUR_W = COORD_BITS + 1;

  logic [2:0][CUR_W-1:0]     cur_r, cur_nxt;
  logic [2:0]                sign_r, sign_nxt;
  logic [2:0][DIST_BITS-1:0] bd_r, bd_nxt;
  logic [2:0][DIST_BITS-1:0] cd_r, cd_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      fin_r, fin_nxt;

  logic [2:0][CUR_W-1:0]     load_cur, step_cur;
  logic [2:0][DIST_BITS-1:0] step_bd, load_bd, load_cd;
  logic [2:0]                code;
  axis_t                     ax;
  logic                      load_in, step_in;

  assign load_cur[0] = CUR_W'(COORD_BITS'(item.start_x));
  assign load_cur[1] = CUR_W'(COORD_BITS'(item.start_y));
  assign load_cur[2] = CUR_W'(COORD_BITS'(item.start_z));
  assign load_bd[0]  = DIST_BITS'(item.tmax_x);
  assign load_bd[1]  = DIST_BITS'(item.tmax_y);
  assign load_bd[2]  = DIST_BITS'(item.tmax_z);
  assign load_cd[0]  = DIST_BITS'(item.tdelta_x);
  assign load_cd[1]  = DIST_BITS'(item.tdelta_y);
  assign load_cd[2]  = DIST_BITS'(item.tdelta_z);

  assign code = {bd_r[0] < bd_r[1], bd_r[0] < bd_r[2], bd_r[1] < bd_r[2]};
  assign ax   = axis_lookup(code);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic               hit;
    logic [DIST_BITS:0] sum;
    assign hit = (ax == axis_t'(2'(a)));
    assign sum = {1'b0, bd_r[a]} + {1'b0, cd_r[a]};
    assign step_cur[a] = !hit      ? cur_r[a] :
                         sign_r[a] ? cur_r[a] - CUR_W'(1) : cur_r[a] + CUR_W'(1);
    // saturate at all ones so infinity stays infinite
    assign step_bd[a]  = !hit ? bd_r[a] :
                         sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
  end

  vrt_bounds #(.COORD_BITS(COORD_BITS)) u_bounds_load (
    .cur       (load_cur),
    .grid_size (grid_size),
    .bounds_ok (load_in)
  );

  vrt_bounds #(.COORD_BITS(COORD_BITS)) u_bounds_step (
    .cur       (step_cur),
    .grid_size (grid_size),
    .bounds_ok (step_in)
  );

  always_comb begin
    cur_nxt  = cur_r;
    sign_nxt = sign_r;
    bd_nxt   = bd_r;
    cd_nxt   = cd_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    res             = '0;
    res.done        = 1'b1;
    res.count       = cnt_r;
    if (item.op == OP_LOAD) begin
      cur_nxt  = load_cur;
      sign_nxt = item.step_neg;
      bd_nxt   = load_bd;
      cd_nxt   = load_cd;
      if (load_in) begin
        fin_nxt         = 1'b0;
        cnt_nxt         = CNT_W'(1);
        res.voxel_x     = VOX_W'(load_cur[0][COORD_BITS-1:0]);
        res.voxel_y     = VOX_W'(load_cur[1][COORD_BITS-1:0]);
        res.voxel_z     = VOX_W'(load_cur[2][COORD_BITS-1:0]);
        res.voxel_valid = 1'b1;
        res.done        = 1'b0;
        res.count       = CNT_W'(1);
      end else begin
        fin_nxt   = 1'b1;
        cnt_nxt   = '0;
        res.count = '0;
      end
    end else if (!fin_r) begin
      cur_nxt = step_cur;
      if (step_in) begin
        if (cnt_r != COUNT_MAX) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        bd_nxt          = step_bd;
        res.voxel_x     = VOX_W'(step_cur[0][COORD_BITS-1:0]);
        res.voxel_y     = VOX_W'(step_cur[1][COORD_BITS-1:0]);
        res.voxel_z     = VOX_W'(step_cur[2][COORD_BITS-1:0]);
        res.voxel_valid = 1'b1;
        res.done        = 1'b0;
        res.count       = cnt_nxt;
      end else begin
        fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      sign_r <= '0;
      bd_r   <= '0;
      cd_r   <= '0;
      cnt_r  <= '0;
      fin_r  <= 1'b1;
    end else if (fire) begin
      cur_r  <= cur_nxt;
      sign_r <= sign_nxt;
      bd_r   <= bd_nxt;
      cd_r   <= cd_nxt;
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_ray_traversal_3d.sv =====
// A request waits in the input register until the result register is free, then passes
// through the core; its result is held on out_* until taken. The block takes one request
// per cycle unless out_stall holds a result; a load or step is one pass through the core.
// The input register, core state and the result register form the whole path.
// Reset (rst_n low, synchronous): no ray loaded, all grid sizes 1024, both registers empty.
// A step with no ray loaded reports done with a count of zero.
`default_nettype none

module voxel_ray_traversal_3d import vrt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration write channel
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_operation,
  input  wire logic [VOX_W-1:0] in_start_x,
  input  wire logic [VOX_W-1:0] in_start_y,
  input  wire logic [VOX_W-1:0] in_start_z,
  input  wire logic [2:0]       in_step_negative,
  input  wire logic [TIN_W-1:0] in_tmax_x,
  input  wire logic [TIN_W-1:0] in_tmax_y,
  input  wire logic [TIN_W-1:0] in_tmax_z,
  input  wire logic [TIN_W-1:0] in_tdelta_x,
  input  wire logic [TIN_W-1:0] in_tdelta_y,
  input  wire logic [TIN_W-1:0] in_tdelta_z,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [VOX_W-1:0]      out_voxel_x,
  output logic [VOX_W-1:0]      out_voxel_y,
  output logic [VOX_W-1:0]      out_voxel_z,
  output logic                  out_voxel_valid,
  output logic                  out_traversal_done,
  output logic [CNT_W-1:0]      out_visited_count
);

  logic [2:0][CFG_W-1:0] grid_r;

  logic  in_vld_r, in_vld_nxt;
  item_t item_r;
  logic  out_vld_r, out_vld_nxt;
  res_t  res_r;
  res_t  res_c;

  logic  in_take;   // request enters the input register
  logic  out_load;  // result register free this cycle
  logic  fire;      // request in the input register moves through the core

  // Configuration writes always complete; issue them only while no request is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= {GRID_RESET, GRID_RESET, GRID_RESET};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_X: grid_r[0] <= cfg_data;
        REG_GRID_Y: grid_r[1] <= cfg_data;
        REG_GRID_Z: grid_r[2] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Handshake: the result register frees up when empty or when taken; the
  // input register stalls while it holds a request and a finished result still waits.
  assign out_load = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_load;
  assign in_stall = in_vld_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op       <= in_operation;
      item_r.start_x  <= in_start_x;
      item_r.start_y  <= in_start_y;
      item_r.start_z  <= in_start_z;
      item_r.step_neg <= in_step_negative;
      item_r.tmax_x   <= in_tmax_x;
      item_r.tmax_y   <= in_tmax_y;
      item_r.tmax_z   <= in_tmax_z;
      item_r.tdelta_x <= in_tdelta_x;
      item_r.tdelta_y <= in_tdelta_y;
      item_r.tdelta_z <= in_tdelta_z;
    end
  end

  // Core: ray state plus one load or one voxel step per fire
  vrt_core #(
    .COORD_BITS (COORD_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .grid_size (grid_r),
    .res       (res_c)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_c;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_voxel_x        = res_r.voxel_x;
  assign out_voxel_y        = res_r.voxel_y;
  assign out_voxel_z        = res_r.voxel_z;
  assign out_voxel_valid    = res_r.voxel_valid;
  assign out_traversal_done = res_r.done;
  assign out_visited_count  = res_r.count;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("core result lost");

  a_valid_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.voxel_valid != res_r.done))
    else $error("voxel_valid and done both set or both clear");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.voxel_valid) |-> (res_r.count != '0))
    else $error("valid voxel reported with zero count");
`endif

endmodule

`default_nettype wire

// ===== sim/vrt_walk_pkg.sv =====
`timescale 1ns / 1ps
// Ray walk tracker for the voxel traversal testbench: predicts each result from the accepted
// requests and checks the results the block returns, field by field, in order.
// Depends on vrt_pkg for the request and result layouts and the code constants.

package vrt_walk_pkg;
  import vrt_pkg::*;

  // Axis picked for each comparison code {tx<ty, tx<tz, ty<tz}
  localparam axis_t AXIS_BY_CODE [8] = '{AXIS_Z, AXIS_Y, AXIS_Z, AXIS_Y,
                                         AXIS_Z, AXIS_Z, AXIS_X, AXIS_X};
  localparam logic [CFG_W-1:0] COORD_SPAN = CFG_W'(1 << VOX_W);
  localparam logic [VOX_W:0]   ONE_VOXEL  = 1;
  localparam int               REPORT_LIMIT = 10;

  class ray_walk_board;
    logic [CFG_W-1:0] grid [3];
    logic [VOX_W:0]   vox [3];
    logic [2:0]       step_neg;
    logic [TIN_W-1:0] t_next [3];
    logic [TIN_W-1:0] t_step [3];
    logic [CNT_W-1:0] visits;
    logic             walk_over;
    res_t             expected_voxels [$];
    int unsigned      errors, checked, loads, steps, exits;

    function new();
      int a;
      for (a = 0; a < 3; a++) begin
        grid[a] = GRID_RESET;
        vox[a] = '0;
        t_next[a] = '0;
        t_step[a] = '0;
      end
      step_neg = '0;
      visits = '0;
      walk_over = 1'b1;
      errors = 0;
      checked = 0;
      loads = 0;
      steps = 0;
      exits = 0;
    endfunction

    function void set_grid(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_GRID_X: grid[0] = val;
        REG_GRID_Y: grid[1] = val;
        REG_GRID_Z: grid[2] = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_voxels.size();
    endfunction

    // Sizes past the coordinate range clamp to the range; size zero holds no voxel.
    function bit in_grid();
      int a;
      logic [CFG_W-1:0] span;
      for (a = 0; a < 3; a++) begin
        span = (grid[a] > COORD_SPAN) ? COORD_SPAN : grid[a];
        if (vox[a] >= span) return 1'b0;
      end
      return 1'b1;
    endfunction

    function res_t report(bit valid);
      res_t r;
      r.voxel_x = valid ? vox[0][VOX_W-1:0] : '0;
      r.voxel_y = valid ? vox[1][VOX_W-1:0] : '0;
      r.voxel_z = valid ? vox[2][VOX_W-1:0] : '0;
      r.voxel_valid = valid;
      r.done = !valid;
      r.count = visits;
      return r;
    endfunction

    function string show(res_t r);
      return $sformatf("voxel (%0d,%0d,%0d) valid %0b done %0b count %0d",
                       r.voxel_x, r.voxel_y, r.voxel_z, r.voxel_valid, r.done, r.count);
    endfunction

    // Advance the walk by one request and queue the result it must produce.
    function void take_request(item_t rq);
      logic [2:0]     code;
      int             ax;
      logic [TIN_W:0] sum;
      if (rq.op == OP_LOAD) begin
        loads++;
        vox[0] = {1'b0, rq.start_x};
        vox[1] = {1'b0, rq.start_y};
        vox[2] = {1'b0, rq.start_z};
        step_neg = rq.step_neg;
        t_next[0] = rq.tmax_x;
        t_next[1] = rq.tmax_y;
        t_next[2] = rq.tmax_z;
        t_step[0] = rq.tdelta_x;
        t_step[1] = rq.tdelta_y;
        t_step[2] = rq.tdelta_z;
        walk_over = !in_grid();
        visits = walk_over ? CNT_W'(0) : CNT_W'(1);
        expected_voxels.push_back(report(!walk_over));
        return;
      end
      steps++;
      if (walk_over) begin
        expected_voxels.push_back(report(1'b0));
        return;
      end
      code = {t_next[0] < t_next[1], t_next[0] < t_next[2], t_next[1] < t_next[2]};
      ax = int'(AXIS_BY_CODE[code]);
      vox[ax] = step_neg[ax] ? vox[ax] - ONE_VOXEL : vox[ax] + ONE_VOXEL;
      if (!in_grid()) begin
        walk_over = 1'b1;
        exits++;
        expected_voxels.push_back(report(1'b0));
        return;
      end
      if (visits != COUNT_MAX) visits++;
      // saturate: all ones stays infinite
      sum = {1'b0, t_next[ax]} + {1'b0, t_step[ax]};
      t_next[ax] = sum[TIN_W] ? '1 : sum[TIN_W-1:0];
      expected_voxels.push_back(report(1'b1));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_voxels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: %s", $time, show(got));
        return;
      end
      want = expected_voxels.pop_front();
      checked++;
      if (got.voxel_x !== want.voxel_x || got.voxel_y !== want.voxel_y ||
          got.voxel_z !== want.voxel_z || got.voxel_valid !== want.voxel_valid ||
          got.done !== want.done || got.count !== want.count) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch, got %s, expected %s", $time, show(got), show(want));
      end
    endfunction
  endclass

endpackage

// ===== sim/voxel_ray_traversal_3d_test.sv =====
`timescale 1ns / 1ps
// Testbench top for voxel_ray_traversal_3d: directed and random rays over several grid sizes,
// random gaps on both channels, and every result checked in order by ray_walk_board.
// Depends on vrt_pkg and vrt_walk_pkg.

module voxel_ray_traversal_3d_test;
  import vrt_pkg::*;
  import vrt_walk_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_STEPS     = 40;
  localparam logic [TIN_W-1:0] T_INF = '1;

  // Grid setting, idle mix and random request budget for each phase
  localparam logic [CFG_W-1:0] GRID_X [PHASES] = '{1024, 1, 12, 0,    2047, 1024, 64};
  localparam logic [CFG_W-1:0] GRID_Y [PHASES] = '{1024, 1, 7,  2047, 1024, 2,    64};
  localparam logic [CFG_W-1:0] GRID_Z [PHASES] = '{1024, 1, 30, 7,    3,    1024, 64};
  localparam int SEND_IDLE [PHASES] = '{28, 28, 59, 59, 0, 0, 0};
  localparam int RECV_IDLE [PHASES] = '{59, 59, 28, 28, 0, 0, 0};
  localparam int RANDOM_REQS [PHASES] = '{230, 120, 280, 40, 250, 200, 200};

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_operation;
  logic [VOX_W-1:0] in_start_x;
  logic [VOX_W-1:0] in_start_y;
  logic [VOX_W-1:0] in_start_z;
  logic [2:0]       in_step_negative;
  logic [TIN_W-1:0] in_tmax_x;
  logic [TIN_W-1:0] in_tmax_y;
  logic [TIN_W-1:0] in_tmax_z;
  logic [TIN_W-1:0] in_tdelta_x;
  logic [TIN_W-1:0] in_tdelta_y;
  logic [TIN_W-1:0] in_tdelta_z;
  logic             out_valid;
  logic             out_stall;
  logic [VOX_W-1:0] out_voxel_x;
  logic [VOX_W-1:0] out_voxel_y;
  logic [VOX_W-1:0] out_voxel_z;
  logic             out_voxel_valid;
  logic             out_traversal_done;
  logic [CNT_W-1:0] out_visited_count;

  ray_walk_board board;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   cycle_count = 0;
  int unsigned   hold_asks = 0;
  int unsigned   hold_taken = 0;
  int unsigned   hold_left = 0;

  voxel_ray_traversal_3d DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run: the slowest correct run stays far below this.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("watchdog: no finish after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Watch all three channels at the rising edge. DUT outputs still hold their pre-edge
  // values here, and every TB input was driven at the falling edge before.
  always @(posedge clk) begin : watch_ports
    item_t rq;
    res_t  rs;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_grid(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        rq = {in_operation, in_start_x, in_start_y, in_start_z, in_step_negative,
              in_tmax_x, in_tmax_y, in_tmax_z, in_tdelta_x, in_tdelta_y, in_tdelta_z};
        board.take_request(rq);
      end
      if (out_valid && !out_stall) begin
        rs = {out_voxel_x, out_voxel_y, out_voxel_z, out_voxel_valid,
              out_traversal_done, out_visited_count};
        board.check_result(rs);
      end
    end
  end

  // Result side: random stall, or a long hold-off counted here once requested.
  // The hold-off lets the sender keep pushing until the block backs up into in_stall.
  always @(negedge clk) begin
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Mix of infinity, zero, small steps, values near the top and anything at all.
  function automatic logic [TIN_W-1:0] pick_dist();
    case ($urandom_range(0, 9))
      0:          return T_INF;
      1:          return '0;
      2, 3, 4, 5: return TIN_W'($urandom_range(0, 32'h0008_0000));
      6:          return T_INF - TIN_W'($urandom_range(0, 32'h0002_0000));
      default:    return TIN_W'($urandom);
    endcase
  endfunction

  // Mostly inside the grid, with the corners, the first voxel past the edge and noise.
  function automatic logic [VOX_W-1:0] pick_coord(logic [CFG_W-1:0] size);
    int span;
    span = (size > CFG_W'(1 << VOX_W)) ? (1 << VOX_W) : int'(size);
    case ($urandom_range(0, 7))
      0:       return VOX_W'($urandom);
      1:       return '0;
      2:       return (span == 0) ? '0 : VOX_W'(span - 1);
      3:       return VOX_W'((span >= (1 << VOX_W)) ? (1 << VOX_W) - 1 : span);
      default: return (span == 0) ? '0 : VOX_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic item_t noise_req();
    item_t r;
    r.op = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_STEP;
    r.start_x = VOX_W'($urandom);
    r.start_y = VOX_W'($urandom);
    r.start_z = VOX_W'($urandom);
    r.step_neg = 3'($urandom);
    r.tmax_x = pick_dist();
    r.tmax_y = pick_dist();
    r.tmax_z = pick_dist();
    r.tdelta_x = pick_dist();
    r.tdelta_y = pick_dist();
    r.tdelta_z = pick_dist();
    return r;
  endfunction

  // Step request: the load fields ride along with random content.
  function automatic item_t step_req();
    item_t r;
    r = noise_req();
    r.op = OP_STEP;
    return r;
  endfunction

  function automatic item_t make_load(logic [VOX_W-1:0] sx, sy, sz, logic [2:0] neg,
                                      logic [TIN_W-1:0] tx, ty, tz, dx, dy, dz);
    item_t r;
    r = '{op: OP_LOAD, start_x: sx, start_y: sy, start_z: sz, step_neg: neg,
          tmax_x: tx, tmax_y: ty, tmax_z: tz, tdelta_x: dx, tdelta_y: dy, tdelta_z: dz};
    return r;
  endfunction

  // Offer one request after a random gap; hold it until the block takes it.
  // Entered and left at a falling edge, so valid is only set once per step.
  task automatic offer(input item_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {in_operation, in_start_x, in_start_y, in_start_z, in_step_negative,
     in_tmax_x, in_tmax_y, in_tmax_z, in_tdelta_x, in_tdelta_y, in_tdelta_z} <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic ray(input item_t load, input int n_steps);
    offer(load);
    repeat (n_steps) offer(step_req());
  endtask

  // Drop valid and wait for every outstanding result, then let the pipe drain.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_grid(input logic [CFG_W-1:0] gx, gy, gz);
    logic [IDX_W-1:0] regs [3] = '{REG_GRID_X, REG_GRID_Y, REG_GRID_Z};
    logic [CFG_W-1:0] vals [3];
    int r;
    vals = '{gx, gy, gz};
    for (r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    int k;
    bit held;
    board = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_X;
    cfg_data = '0;
    in_valid = 1'b0;
    {in_operation, in_start_x, in_start_y, in_start_z, in_step_negative,
     in_tmax_x, in_tmax_y, in_tmax_z, in_tdelta_x, in_tdelta_y, in_tdelta_z} = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      // Block is idle here: right after reset, or after the previous drain.
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      write_grid(GRID_X[ph], GRID_Y[ph], GRID_Z[ph]);

      case (ph)
        0: begin
          // Step with no ray loaded yet: done, count zero.
          offer(step_req());
          // Far corner, all distances infinite: ties go to z, which leaves the grid,
          // and the step after that only repeats done.
          ray(make_load(10'd1023, 10'd1023, 10'd1023, 3'b000,
                        T_INF, T_INF, T_INF, T_INF, T_INF, T_INF), 2);
          // Step back from the origin on x: coordinate wraps below zero.
          ray(make_load(10'd0, 10'd0, 10'd0, 3'b111, 0, 1, 2, 1, 1, 1), 1);
          // Rays for comparison codes 001, 011, 100 and 110; y steps both ways, z and x step down.
          ray(make_load(10'd5, 10'd5, 10'd5, 3'b000, 3, 1, 2, 4, 4, 4), 1);
          ray(make_load(10'd5, 10'd5, 10'd5, 3'b010, 2, 1, 3, 4, 4, 4), 1);
          ray(make_load(10'd5, 10'd5, 10'd5, 3'b100, 2, 3, 1, 4, 4, 4), 1);
          ray(make_load(10'd5, 10'd5, 10'd5, 3'b001, 1, 3, 2, 4, 4, 4), 1);
          // Distance add overflows and must clamp to infinity.
          ray(make_load(10'd10, 10'd10, 10'd10, 3'b000,
                        T_INF - 255, T_INF, T_INF, T_INF, 0, 0), 2);
        end
        1: ray(make_load(10'd0, 10'd0, 10'd0, 3'b000, 0, 0, 0, 0, 0, 0), 2);
        // Zero-sized x axis: every start is outside.
        3: ray(make_load(10'd0, 10'd0, 10'd0, 3'b000, 1, 2, 3, 1, 1, 1), 1);
        default: ;
      endcase

      // Random rays: a load then a run of steps, with some stray requests mixed in.
      n = 0;
      held = 1'b0;
      while (n < RANDOM_REQS[ph]) begin
        if ($urandom_range(0, 9) == 0) begin
          offer(noise_req());
          n++;
        end else begin
          k = $urandom_range(0, MAX_STEPS);
          ray(make_load(pick_coord(GRID_X[ph]), pick_coord(GRID_Y[ph]),
                        pick_coord(GRID_Z[ph]), 3'($urandom), pick_dist(), pick_dist(),
                        pick_dist(), pick_dist(), pick_dist(), pick_dist()), k);
          n += k + 1;
        end
        if (!held && n >= 60 && (ph == 2 || ph == 5)) begin
          hold_asks++;
          held = 1'b1;
        end
      end
      quiesce();
    end

    $display("Covered %0d loads and %0d steps over %0d grid settings, with idle mixes and",
             board.loads, board.steps, PHASES);
    $display("long result hold-offs; %0d results checked, %0d rays left the grid, %0d errors.",
             board.checked, board.exits, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== voxel_ray_traversal_3d.f =====
hw/rtl/vrt_pkg.sv
hw/rtl/vrt_bounds.sv
hw/rtl/vrt_core.sv
hw/rtl/voxel_ray_traversal_3d.sv
sim/vrt_walk_pkg.sv
sim/voxel_ray_traversal_3d_test.sv
